FILE: rtl/tcphc_pkg.sv
// ----------------------------------------------------------------------------
// tcphc_pkg
// Shared types and constants for the TCP scan header classifier.
// ----------------------------------------------------------------------------
package tcphc_pkg;

  localparam logic [7:0] ETH_HDR_LEN   = 8'd14;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] XMAS_FLAGS    = 8'h29;
  localparam logic [7:0] POS_PROTOCOL  = 8'd23;
  localparam logic [7:0] POS_SRC_IP    = 8'd26;
  localparam logic [7:0] POS_DST_IP    = 8'd30;
  localparam logic [7:0] POS_IP_END    = 8'd34;
  localparam logic [7:0] POS_SRC_MAC   = 8'd6;
  localparam logic [7:0] POS_ETYPE     = 8'd12;
  localparam logic [7:0] TCP_DOFF_OFS  = 8'd12;
  localparam logic [7:0] TCP_FLAGS_OFS = 8'd13;
  localparam logic [7:0] BYTE_IDX_MAX  = 8'hFF;

  typedef enum logic [2:0] {
    ST_NORMAL  = 3'd0,
    ST_NULL    = 3'd1,
    ST_XMAS    = 3'd2,
    ST_BAD_IP  = 3'd3,
    ST_BAD_TCP = 3'd4,
    ST_TRUNC   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
  } result_t;

endpackage

FILE: rtl/tcphc_in_stage.sv
// ----------------------------------------------------------------------------
// tcphc_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module tcphc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  input  logic              take,
  output logic              beat_valid,
  output tcphc_pkg::beat_t  beat
);

  logic load;

  assign in_stall = beat_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (load) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat.byte_value <= byte_value;
      beat.last_byte  <= last_byte;
    end
  end

endmodule

FILE: rtl/tcphc_parser.sv
// ----------------------------------------------------------------------------
// tcphc_parser
// Frame state: byte offset, header lengths and captured fields, with the
// capture and classification logic for the beat being taken.
// ----------------------------------------------------------------------------
module tcphc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  tcphc_pkg::beat_t   beat,
  output tcphc_pkg::result_t result
);

  logic [7:0]  byte_index;
  logic [3:0]  ip_words;
  logic [3:0]  tcp_words;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] ether_type;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  flags;

  logic [7:0]  byte_index_next;
  logic [3:0]  ip_words_next;
  logic [3:0]  tcp_words_next;
  logic [47:0] dst_mac_next;
  logic [47:0] src_mac_next;
  logic [15:0] ether_type_next;
  logic [31:0] src_ip_next;
  logic [31:0] dst_ip_next;
  logic [7:0]  protocol_next;
  logic [15:0] src_port_next;
  logic [15:0] dst_port_next;
  logic [7:0]  flags_next;

  logic [7:0]  pos;
  logic [7:0]  b;
  logic [7:0]  tcp_start;
  logic [7:0]  tcp_ofs;
  logic [7:0]  tcp_start_new;
  tcphc_pkg::status_t status;

  assign pos           = byte_index;
  assign b             = beat.byte_value;
  assign tcp_start     = tcphc_pkg::ETH_HDR_LEN + {2'b00, ip_words, 2'b00};
  assign tcp_ofs       = pos - tcp_start;
  assign tcp_start_new = tcphc_pkg::ETH_HDR_LEN + {2'b00, ip_words_next, 2'b00};

  always_comb begin
    byte_index_next = (byte_index != tcphc_pkg::BYTE_IDX_MAX) ? byte_index + 8'd1
                                                             : byte_index;
    ip_words_next   = ip_words;
    tcp_words_next  = tcp_words;
    dst_mac_next    = dst_mac;
    src_mac_next    = src_mac;
    ether_type_next = ether_type;
    src_ip_next     = src_ip;
    dst_ip_next     = dst_ip;
    protocol_next   = protocol;
    src_port_next   = src_port;
    dst_port_next   = dst_port;
    flags_next      = flags;

    if (pos < tcphc_pkg::POS_SRC_MAC) begin
      dst_mac_next = {dst_mac[39:0], b};
    end else if (pos < tcphc_pkg::POS_ETYPE) begin
      src_mac_next = {src_mac[39:0], b};
    end else if (pos < tcphc_pkg::ETH_HDR_LEN) begin
      ether_type_next = {ether_type[7:0], b};
    end else if (pos == tcphc_pkg::ETH_HDR_LEN) begin
      ip_words_next = b[3:0];
    end else if (pos == tcphc_pkg::POS_PROTOCOL) begin
      protocol_next = b;
    end else if (pos >= tcphc_pkg::POS_SRC_IP && pos < tcphc_pkg::POS_DST_IP) begin
      src_ip_next = {src_ip[23:0], b};
    end else if (pos >= tcphc_pkg::POS_DST_IP && pos < tcphc_pkg::POS_IP_END) begin
      dst_ip_next = {dst_ip[23:0], b};
    end

    if (pos > tcphc_pkg::ETH_HDR_LEN && ip_words >= tcphc_pkg::MIN_HDR_WORDS
        && pos >= tcp_start) begin
      if (tcp_ofs < 8'd2) begin
        src_port_next = {src_port[7:0], b};
      end else if (tcp_ofs < 8'd4) begin
        dst_port_next = {dst_port[7:0], b};
      end else if (tcp_ofs == tcphc_pkg::TCP_DOFF_OFS) begin
        tcp_words_next = b[7:4];
      end else if (tcp_ofs == tcphc_pkg::TCP_FLAGS_OFS) begin
        flags_next = b;
      end
    end

    if (pos < tcphc_pkg::ETH_HDR_LEN) begin
      status = tcphc_pkg::ST_TRUNC;
    end else if (ip_words_next < tcphc_pkg::MIN_HDR_WORDS) begin
      status = tcphc_pkg::ST_BAD_IP;
    end else if (pos < tcp_start_new + tcphc_pkg::TCP_DOFF_OFS) begin
      status = tcphc_pkg::ST_TRUNC;
    end else if (tcp_words_next < tcphc_pkg::MIN_HDR_WORDS) begin
      status = tcphc_pkg::ST_BAD_TCP;
    end else if (pos < tcp_start_new + tcphc_pkg::TCP_FLAGS_OFS) begin
      status = tcphc_pkg::ST_TRUNC;
    end else if (flags_next == tcphc_pkg::XMAS_FLAGS) begin
      status = tcphc_pkg::ST_XMAS;
    end else if (flags_next == 8'h00) begin
      status = tcphc_pkg::ST_NULL;
    end else begin
      status = tcphc_pkg::ST_NORMAL;
    end
  end

  assign result.status      = status;
  assign result.dst_mac     = dst_mac_next;
  assign result.src_mac     = src_mac_next;
  assign result.ether_type  = ether_type_next;
  assign result.src_ip      = src_ip_next;
  assign result.dst_ip      = dst_ip_next;
  assign result.ip_protocol = protocol_next;
  assign result.src_port    = src_port_next;
  assign result.dst_port    = dst_port_next;
  assign result.tcp_flags   = flags_next;

  // clear everything on reset and at the end of a frame
  always_ff @(posedge clk) begin
    if (rst || (take && beat.last_byte)) begin
      byte_index <= '0;
      ip_words   <= '0;
      tcp_words  <= '0;
      dst_mac    <= '0;
      src_mac    <= '0;
      ether_type <= '0;
      src_ip     <= '0;
      dst_ip     <= '0;
      protocol   <= '0;
      src_port   <= '0;
      dst_port   <= '0;
      flags      <= '0;
    end else if (take) begin
      byte_index <= byte_index_next;
      ip_words   <= ip_words_next;
      tcp_words  <= tcp_words_next;
      dst_mac    <= dst_mac_next;
      src_mac    <= src_mac_next;
      ether_type <= ether_type_next;
      src_ip     <= src_ip_next;
      dst_ip     <= dst_ip_next;
      protocol   <= protocol_next;
      src_port   <= src_port_next;
      dst_port   <= dst_port_next;
      flags      <= flags_next;
    end
  end

endmodule

FILE: rtl/tcphc_out_stage.sv
// ----------------------------------------------------------------------------
// tcphc_out_stage
// Result register: holds one classified frame until the sink takes it.
// ----------------------------------------------------------------------------
module tcphc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tcphc_pkg::result_t result,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output tcphc_pkg::result_t held
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

FILE: rtl/tcp_scan_header_classifier_unit.sv
// ----------------------------------------------------------------------------
// tcp_scan_header_classifier_unit
// Parses an Ethernet/IPv4/TCP frame one byte a beat and gives one result
// beat with the header fields and a scan status on the last byte.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | byte_value, last_byte
//   out     | out_valid, out_stall| status, macs, ether_type, ips, protocol,
//           |                     | ports, tcp_flags
//
// One byte beat per cycle while in_stall is low; the last byte is taken from the
// input register into the result register once that is free, and out_valid
// rises when the result register loads.
// Frame state is updated in a single pass between the two registers.
// rst clears frame state and both stage valids.
// A stalled output holds the result; a last byte waits in the input
// register until the result register is free, other bytes keep flowing.
// ----------------------------------------------------------------------------
module tcp_scan_header_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [47:0] dst_mac,
  output logic [47:0] src_mac,
  output logic [15:0] ether_type,
  output logic [31:0] src_ip,
  output logic [31:0] dst_ip,
  output logic [7:0]  ip_protocol,
  output logic [15:0] src_port,
  output logic [15:0] dst_port,
  output logic [7:0]  tcp_flags
);

  tcphc_pkg::beat_t   beat;
  tcphc_pkg::result_t result;
  tcphc_pkg::result_t held;
  logic               beat_valid;
  logic               take;
  logic               free;

  assign take = beat_valid && (!beat.last_byte || free);

  tcphc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  tcphc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .beat   (beat),
    .result (result)
  );

  tcphc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && beat.last_byte),
    .result    (result),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign status      = held.status;
  assign dst_mac     = held.dst_mac;
  assign src_mac     = held.src_mac;
  assign ether_type  = held.ether_type;
  assign src_ip      = held.src_ip;
  assign dst_ip      = held.dst_ip;
  assign ip_protocol = held.ip_protocol;
  assign src_port    = held.src_port;
  assign dst_port    = held.dst_port;
  assign tcp_flags   = held.tcp_flags;

endmodule

FILE: tb/tcp_scan_header_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// tcp_scan_header_classifier_unit_tb
// Self-checking bench for the Ethernet/IPv4/TCP header classifier.
// Frames go in one byte per beat. A short table of directed frames comes
// first: edge lengths, short IP and TCP headers, the scan flag patterns,
// all-zero and all-one frames, and a frame long enough to saturate the byte
// count. Random frames follow, most of them well formed with random content
// and the rest cut short or carrying bad header lengths. A predictor tracks
// the header state beat by beat and queues one expected result per last byte.
// Each result beat is compared field by field with the oldest expectation.
// Both sides idle at random, apart from one stretch with no idling.
// ----------------------------------------------------------------------------
module tcp_scan_header_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    int                 len;
    logic [3:0]         ihl;
    logic [3:0]         doff;
    logic [7:0]         flags;
    fill_t              fill;
    bit                 pinned;
    tcphc_pkg::status_t st;
  } frame_row_t;

  typedef struct {
    bit                 pinned;
    tcphc_pkg::status_t st;
  } pin_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] ether_type;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  ip_protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  tcp_flags;

  bit          idle_on = 1'b1;
  int          errors = 0;
  int          beats_sent = 0;
  int          frames_sent = 0;

  logic [7:0]         frame_pos = '0;
  logic [3:0]         ip_hdr_words = '0;
  logic [3:0]         tcp_hdr_words = '0;
  tcphc_pkg::result_t hdr_fields = '0;
  tcphc_pkg::result_t header_q [$];
  pin_t               frame_pin_q [$];

  frame_row_t  directed_frames [17] = '{
    '{  1, 4'h5, 4'h5, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_TRUNC},
    '{ 14, 4'h5, 4'h5, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_TRUNC},
    '{ 15, 4'h4, 4'h5, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_BAD_IP},
    '{ 20, 4'h0, 4'h0, 8'h00, FILL_ZERO, 1'b1, tcphc_pkg::ST_BAD_IP},
    '{ 46, 4'h5, 4'h5, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_TRUNC},
    '{ 47, 4'h5, 4'h4, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_BAD_TCP},
    '{ 47, 4'h5, 4'h5, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_TRUNC},
    '{ 48, 4'h5, 4'h0, 8'h10, FILL_RAND, 1'b1, tcphc_pkg::ST_BAD_TCP},
    '{ 48, 4'h5, 4'h5, 8'h00, FILL_RAND, 1'b1, tcphc_pkg::ST_NULL},
    '{ 48, 4'h5, 4'h5, 8'h29, FILL_RAND, 1'b1, tcphc_pkg::ST_XMAS},
    '{ 48, 4'h5, 4'h5, 8'h2B, FILL_RAND, 1'b0, tcphc_pkg::ST_NORMAL},
    '{ 50, 4'h5, 4'h5, 8'h01, FILL_RAND, 1'b0, tcphc_pkg::ST_NORMAL},
    '{ 88, 4'hF, 4'hF, 8'h29, FILL_RAND, 1'b1, tcphc_pkg::ST_XMAS},
    '{ 87, 4'hF, 4'hF, 8'h29, FILL_RAND, 1'b1, tcphc_pkg::ST_TRUNC},
    '{ 90, 4'hF, 4'hF, 8'hFF, FILL_ONES, 1'b1, tcphc_pkg::ST_NORMAL},
    '{260, 4'h5, 4'h5, 8'h18, FILL_RAND, 1'b0, tcphc_pkg::ST_NORMAL},
    '{ 54, 4'h5, 4'h5, 8'h29, FILL_ZERO, 1'b1, tcphc_pkg::ST_XMAS}
  };

  tcp_scan_header_classifier_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_value  (byte_value),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .dst_mac     (dst_mac),
    .src_mac     (src_mac),
    .ether_type  (ether_type),
    .src_ip      (src_ip),
    .dst_ip      (dst_ip),
    .ip_protocol (ip_protocol),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .tcp_flags   (tcp_flags)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic tcphc_pkg::status_t classify_frame(int p);
    int t;
    if (p < tcphc_pkg::ETH_HDR_LEN) return tcphc_pkg::ST_TRUNC;
    if (ip_hdr_words < tcphc_pkg::MIN_HDR_WORDS) return tcphc_pkg::ST_BAD_IP;
    t = tcphc_pkg::ETH_HDR_LEN + 4 * ip_hdr_words;
    if (p < t + tcphc_pkg::TCP_DOFF_OFS) return tcphc_pkg::ST_TRUNC;
    if (tcp_hdr_words < tcphc_pkg::MIN_HDR_WORDS) return tcphc_pkg::ST_BAD_TCP;
    if (p < t + tcphc_pkg::TCP_FLAGS_OFS) return tcphc_pkg::ST_TRUNC;
    if (hdr_fields.tcp_flags == tcphc_pkg::XMAS_FLAGS) return tcphc_pkg::ST_XMAS;
    if (hdr_fields.tcp_flags == 8'h00) return tcphc_pkg::ST_NULL;
    return tcphc_pkg::ST_NORMAL;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic lst);
    int                 p;
    int                 t;
    int                 r;
    tcphc_pkg::result_t res;
    pin_t               pin;
    p = int'(frame_pos);
    if (p < tcphc_pkg::POS_SRC_MAC)
      hdr_fields.dst_mac = {hdr_fields.dst_mac[39:0], b};
    else if (p < tcphc_pkg::POS_ETYPE)
      hdr_fields.src_mac = {hdr_fields.src_mac[39:0], b};
    else if (p < tcphc_pkg::ETH_HDR_LEN)
      hdr_fields.ether_type = {hdr_fields.ether_type[7:0], b};
    else if (p == tcphc_pkg::ETH_HDR_LEN) ip_hdr_words = b[3:0];
    else if (p == tcphc_pkg::POS_PROTOCOL) hdr_fields.ip_protocol = b;
    else if (p >= tcphc_pkg::POS_SRC_IP && p < tcphc_pkg::POS_DST_IP)
      hdr_fields.src_ip = {hdr_fields.src_ip[23:0], b};
    else if (p >= tcphc_pkg::POS_DST_IP && p < tcphc_pkg::POS_IP_END)
      hdr_fields.dst_ip = {hdr_fields.dst_ip[23:0], b};
    if (p > tcphc_pkg::ETH_HDR_LEN && ip_hdr_words >= tcphc_pkg::MIN_HDR_WORDS) begin
      t = tcphc_pkg::ETH_HDR_LEN + 4 * ip_hdr_words;
      if (p >= t) begin
        r = p - t;
        if (r < 2) hdr_fields.src_port = {hdr_fields.src_port[7:0], b};
        else if (r < 4) hdr_fields.dst_port = {hdr_fields.dst_port[7:0], b};
        else if (r == tcphc_pkg::TCP_DOFF_OFS) tcp_hdr_words = b[7:4];
        else if (r == tcphc_pkg::TCP_FLAGS_OFS) hdr_fields.tcp_flags = b;
      end
    end
    if (frame_pos != tcphc_pkg::BYTE_IDX_MAX) frame_pos = frame_pos + 8'd1;
    if (lst) begin
      res = hdr_fields;
      res.status = classify_frame(p);
      if (frame_pin_q.size() != 0) begin
        pin = frame_pin_q.pop_front();
        if (pin.pinned) res.status = pin.st;
      end
      header_q.push_back(res);
      frame_pos = '0;
      ip_hdr_words = '0;
      tcp_hdr_words = '0;
      hdr_fields = '0;
    end
  endtask

  function automatic void check_field(string name, logic [47:0] exp, logic [47:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp, act);
    end
  endfunction

  task automatic check_result();
    tcphc_pkg::result_t exp;
    if (header_q.size() == 0) begin
      errors++;
      $display("%0t: result beat with none expected, status actual %0d", $time, status);
    end else begin
      exp = header_q.pop_front();
      check_field("status", 48'(exp.status), 48'(status));
      check_field("dst_mac", exp.dst_mac, dst_mac);
      check_field("src_mac", exp.src_mac, src_mac);
      check_field("ether_type", 48'(exp.ether_type), 48'(ether_type));
      check_field("src_ip", 48'(exp.src_ip), 48'(src_ip));
      check_field("dst_ip", 48'(exp.dst_ip), 48'(dst_ip));
      check_field("ip_protocol", 48'(exp.ip_protocol), 48'(ip_protocol));
      check_field("src_port", 48'(exp.src_port), 48'(src_port));
      check_field("dst_port", 48'(exp.dst_port), 48'(dst_port));
      check_field("tcp_flags", 48'(exp.tcp_flags), 48'(tcp_flags));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) track_byte(byte_value, last_byte);
      if (out_valid && !out_stall) check_result();
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 29);
  end

  task automatic send_beat(input logic [7:0] b, input logic lst);
    while (idle_on && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_frame(input frame_row_t row);
    logic [7:0] fb [0:511];
    int         t;
    int         i;
    pin_t       pin;
    pin.pinned = row.pinned;
    pin.st     = row.st;
    for (i = 0; i < row.len; i++) begin
      case (row.fill)
        FILL_ZERO: fb[i] = 8'h00;
        FILL_ONES: fb[i] = 8'hFF;
        default:   fb[i] = 8'($urandom);
      endcase
    end
    if (row.len > tcphc_pkg::ETH_HDR_LEN) fb[tcphc_pkg::ETH_HDR_LEN][3:0] = row.ihl;
    t = tcphc_pkg::ETH_HDR_LEN + 4 * row.ihl;
    if (row.ihl >= tcphc_pkg::MIN_HDR_WORDS) begin
      if (t + tcphc_pkg::TCP_DOFF_OFS < row.len)
        fb[t + tcphc_pkg::TCP_DOFF_OFS][7:4] = row.doff;
      if (t + tcphc_pkg::TCP_FLAGS_OFS < row.len)
        fb[t + tcphc_pkg::TCP_FLAGS_OFS] = row.flags;
    end
    frame_pin_q.push_back(pin);
    for (i = 0; i < row.len; i++) send_beat(fb[i], i == row.len - 1);
  endtask

  function automatic frame_row_t random_frame();
    frame_row_t row;
    int         pick;
    int         t;
    pick       = $urandom_range(0, 99);
    row.fill   = FILL_RAND;
    row.pinned = 1'b0;
    row.st     = tcphc_pkg::ST_NORMAL;
    row.ihl    = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    row.doff   = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    if ($urandom_range(0, 9) == 0) row.doff = 4'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0:       row.flags = 8'h00;
      1:       row.flags = tcphc_pkg::XMAS_FLAGS;
      default: row.flags = 8'($urandom);
    endcase
    t = tcphc_pkg::ETH_HDR_LEN + 4 * row.ihl;
    if (pick < 70) begin
      row.len = t + tcphc_pkg::TCP_FLAGS_OFS + 1 + $urandom_range(0, 16);
    end else if (pick < 72) begin
      row.len = $urandom_range(256, 290);
    end else begin
      row.ihl  = 4'($urandom_range(0, 15));
      row.doff = 4'($urandom_range(0, 15));
      row.len  = $urandom_range(1, tcphc_pkg::ETH_HDR_LEN + 4 * row.ihl + 16);
    end
    return row;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (header_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 17; i++) begin
      idle_on = !(i >= 12 && i < 16);
      send_frame(directed_frames[i]);
    end
    idle_on = 1'b1;
    // hold the sender until every result is back
    drain_results();
    while (beats_sent < 1300) begin
      if (frames_sent == 2) drain_results();
      send_frame(random_frame());
      frames_sent++;
    end
    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcphc_pkg.sv
rtl/tcphc_in_stage.sv
rtl/tcphc_parser.sv
rtl/tcphc_out_stage.sv
rtl/tcp_scan_header_classifier_unit.sv
tb/tcp_scan_header_classifier_unit_tb.sv
